@@ src/hcbp_pkg.sv @@
// Package for the Huffman code bit packer.
// Holds the sizing constants, the payload and byte-group structs and a helper.
// No dependencies.
`default_nettype none

package hcbp_pkg;

    // Number of symbols that have a code table entry.
    localparam int SYMBOL_COUNT  = 256;
    // Longest code that may be loaded.
    localparam int MAX_CODE_BITS = 32;

    // Code bits kept per entry: the field width, capped by MAX_CODE_BITS.
    localparam int CODE_W   = 32;
    localparam int CODE_CAP = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
    localparam int LEN_W    = 6;
    localparam int SYM_W    = 8;
    localparam int ADDR_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    // Up to four full bytes from one code plus one flush byte.
    localparam int GROUP_BYTES = 5;
    localparam int CNT_W       = 3;
    // Pending byte on top of a full code word.
    localparam int ACC_W       = 8 + CODE_W;

    // Item actions.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_ENCODE = 1'b1;

    typedef struct packed {
        logic              action;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_value;
        logic [LEN_W-1:0]  code_length;
        logic              end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    // Bytes produced by one item, first byte in entry 0.
    typedef struct packed {
        logic [GROUP_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
    } group_t;

    // True when the symbol has a code table entry.
    function automatic logic sym_in_range(input logic [SYM_W-1:0] sym);
        return ({1'b0, sym} < (SYM_W+1)'(SYMBOL_COUNT));
    endfunction

endpackage

`default_nettype wire

@@ src/huffman_code_bit_packer_unit.sv @@
// Huffman code bit packer, top level.
// Path: the first result byte passes the table read and item stage registers,
// then the serializer's group register, and can stall behind a busy serializer.
// Throughput: one item per cycle while the result side keeps up; an item producing k
// bytes holds the single-byte result port for k transactions, up to five per item.
// Reset: pending bits and all table valid bits clear at once; no clearing pass.
// Depends on hcbp_pkg, hcbp_code_store, hcbp_bit_packer, hcbp_byte_serializer.
`default_nettype none

module huffman_code_bit_packer_unit (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire hcbp_pkg::in_item_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output hcbp_pkg::out_item_t       m_data
);

    logic                          s_fire;
    logic                          wr_en;
    logic [hcbp_pkg::CODE_W-1:0]   rd_code;
    logic [hcbp_pkg::LEN_W-1:0]    rd_length;
    logic                          grp_valid;
    logic                          grp_ready;
    hcbp_pkg::group_t              grp;

    assign s_fire = s_valid && s_ready;
    assign wr_en  = s_fire && (s_data.action == hcbp_pkg::ACT_LOAD)
                  && hcbp_pkg::sym_in_range(s_data.symbol);

    // Code table: loads write, every accepted item reads
    hcbp_code_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (s_data.symbol[hcbp_pkg::ADDR_W-1:0]),
        .wr_value  (s_data.code_value),
        .wr_length (s_data.code_length),
        .rd_en     (s_fire),
        .rd_addr   (s_data.symbol[hcbp_pkg::ADDR_W-1:0]),
        .rd_code   (rd_code),
        .rd_length (rd_length)
    );

    // Bit packing against the pending partial byte
    hcbp_bit_packer u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_load   (s_fire),
        .in_item   (s_data),
        .in_ready  (s_ready),
        .rd_code   (rd_code),
        .rd_length (rd_length),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp)
    );

    // Byte-wide result channel
    hcbp_byte_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

@@ src/hcbp_code_store.sv @@
// Code table for the bit packer: one entry per symbol, code stored left-aligned.
// Valid bits cleared at reset make unloaded entries read as length zero.
// Depends on hcbp_pkg.
`default_nettype none

module hcbp_code_store (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            wr_en,
    input  wire logic [hcbp_pkg::ADDR_W-1:0]     wr_addr,
    input  wire logic [hcbp_pkg::CODE_W-1:0]     wr_value,
    input  wire logic [hcbp_pkg::LEN_W-1:0]      wr_length,
    input  wire logic                            rd_en,
    input  wire logic [hcbp_pkg::ADDR_W-1:0]     rd_addr,
    output logic      [hcbp_pkg::CODE_W-1:0]     rd_code,
    output logic      [hcbp_pkg::LEN_W-1:0]      rd_length
);

    localparam int ENTRY_W = hcbp_pkg::CODE_W + hcbp_pkg::LEN_W;

    logic [ENTRY_W-1:0]                  mem [hcbp_pkg::SYMBOL_COUNT];
    logic [hcbp_pkg::SYMBOL_COUNT-1:0]   valid_reg;
    logic [ENTRY_W-1:0]                  rd_data_reg;
    logic                                rd_valid_reg;

    logic [hcbp_pkg::LEN_W-1:0]  len_sat;
    logic [hcbp_pkg::LEN_W-1:0]  shift_amt;
    logic [hcbp_pkg::CODE_W-1:0] code_left;

    // Saturate the length, then left-align the code; bits above the length drop out
    always_comb begin
        if (wr_length > hcbp_pkg::LEN_W'(hcbp_pkg::CODE_CAP)) begin
            len_sat = hcbp_pkg::LEN_W'(hcbp_pkg::CODE_CAP);
        end else begin
            len_sat = wr_length;
        end
        shift_amt = hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - len_sat;
        code_left = wr_value << shift_amt;
    end

    // Entry storage with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {code_left, len_sat};
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Per-entry valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Never-written entries read as an empty code
    assign rd_code   = rd_valid_reg ? rd_data_reg[ENTRY_W-1 -: hcbp_pkg::CODE_W] : '0;
    assign rd_length = rd_valid_reg ? rd_data_reg[hcbp_pkg::LEN_W-1:0] : '0;

endmodule

`default_nettype wire

@@ src/hcbp_bit_packer.sv @@
// Packing stage: merges the looked-up code with the pending partial byte.
// Holds the pending state and hands each item's bytes on as one group.
// Depends on hcbp_pkg.
`default_nettype none

module hcbp_bit_packer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_load,
    input  wire hcbp_pkg::in_item_t            in_item,
    output logic                               in_ready,
    input  wire logic [hcbp_pkg::CODE_W-1:0]   rd_code,
    input  wire logic [hcbp_pkg::LEN_W-1:0]    rd_length,
    output logic                               grp_valid,
    input  wire logic                          grp_ready,
    output hcbp_pkg::group_t                   grp
);

    localparam int TOT_W = hcbp_pkg::LEN_W + 1;

    logic       a_valid_reg;
    logic       a_encode_reg;
    logic       a_eos_reg;
    logic       a_in_range_reg;
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic [2:0] pend_cnt_reg, pend_cnt_next;

    logic [hcbp_pkg::CODE_W-1:0] code;
    logic [hcbp_pkg::LEN_W-1:0]  len;
    logic [TOT_W-1:0]            total;
    logic [hcbp_pkg::CNT_W-1:0]  nfull;
    logic [hcbp_pkg::ACC_W-1:0]  aligned;
    logic [hcbp_pkg::CNT_W-1:0]  count;
    logic [7:0]                  partial;
    logic                        a_fire;

    // Stage register for the item whose table read is in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (in_load) begin
            a_valid_reg <= 1'b1;
        end else if (a_fire) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            a_encode_reg   <= (in_item.action == hcbp_pkg::ACT_ENCODE);
            a_eos_reg      <= in_item.end_of_stream;
            a_in_range_reg <= hcbp_pkg::sym_in_range(in_item.symbol);
        end
    end

    // Pending bits left-aligned; the code lands right behind them
    always_comb begin
        code    = a_in_range_reg ? rd_code : '0;
        len     = a_in_range_reg ? rd_length : '0;
        total   = TOT_W'(pend_cnt_reg) + TOT_W'(len);
        nfull   = total[5:3];
        aligned = {pend_byte_reg, hcbp_pkg::CODE_W'(0)}
                | ({code, 8'h00} >> pend_cnt_reg);
        for (int k = 0; k < hcbp_pkg::GROUP_BYTES; k++) begin
            grp.bytes[k] = aligned[hcbp_pkg::ACC_W-1-8*k -: 8];
        end
        // Byte after the full ones is the new partial (zero padded)
        partial = '0;
        for (int k = 0; k < hcbp_pkg::GROUP_BYTES; k++) begin
            if (nfull == hcbp_pkg::CNT_W'(k)) begin
                partial = grp.bytes[k];
            end
        end
        if (a_encode_reg) begin
            count = nfull + hcbp_pkg::CNT_W'(a_eos_reg);
        end else begin
            count = '0;
        end
        grp.count = count;
    end

    // Items with no bytes retire without waiting on the output side
    assign grp_valid = a_valid_reg && (count != '0);
    assign a_fire    = a_valid_reg && ((count == '0) || grp_ready);
    assign in_ready  = !a_valid_reg || a_fire;

    // Pending state update
    always_comb begin
        pend_byte_next = pend_byte_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (a_fire && a_encode_reg) begin
            if (a_eos_reg) begin
                pend_byte_next = '0;
                pend_cnt_next  = '0;
            end else begin
                pend_byte_next = partial;
                pend_cnt_next  = total[2:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_byte_reg <= '0;
            pend_cnt_reg  <= '0;
        end else begin
            pend_byte_reg <= pend_byte_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ src/hcbp_byte_serializer.sv @@
// Output stage: holds one item's byte group and sends it a byte per transaction.
// Takes the next group as the last byte of the current one leaves.
// Depends on hcbp_pkg.
`default_nettype none

module hcbp_byte_serializer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                grp_valid,
    output logic                     grp_ready,
    input  wire hcbp_pkg::group_t    grp,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output hcbp_pkg::out_item_t      m_data
);

    logic [hcbp_pkg::GROUP_BYTES-1:0][7:0] bytes_reg, bytes_next;
    logic [hcbp_pkg::CNT_W-1:0]            cnt_reg, cnt_next;
    logic                                  m_fire;
    logic                                  grp_fire;

    assign m_valid   = (cnt_reg != '0);
    assign m_fire    = m_valid && m_ready;
    assign grp_ready = !m_valid || (m_ready && (cnt_reg == hcbp_pkg::CNT_W'(1)));
    assign grp_fire  = grp_valid && grp_ready;

    assign m_data.out_byte    = bytes_reg[0];
    assign m_data.last_of_run = (cnt_reg == hcbp_pkg::CNT_W'(1));

    // Load a new group, or shift the sent byte out
    always_comb begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        if (grp_fire) begin
            bytes_next = grp.bytes;
            cnt_next   = grp.count;
        end else if (m_fire) begin
            for (int k = 0; k < hcbp_pkg::GROUP_BYTES - 1; k++) begin
                bytes_next[k] = bytes_reg[k+1];
            end
            bytes_next[hcbp_pkg::GROUP_BYTES-1] = '0;
            cnt_next = cnt_reg - hcbp_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ verif/hcbp_stream_checker.sv @@
// Stream checker for huffman_code_bit_packer_unit: predicts the packed byte stream
// and compares every result transaction against it.
// Depends on hcbp_pkg for the payload structs and sizing constants.

module hcbp_stream_checker
    import hcbp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_item_t  s_data,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_item_t m_data,
    output int             fail_count,
    output int             bytes_owed
);

    // Shadow code table and bit accumulator
    logic [CODE_W-1:0] code_bits [SYMBOL_COUNT];
    int                code_len  [SYMBOL_COUNT];
    logic [7:0]        acc_byte;
    int                acc_count;
    out_item_t         expected_bytes[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Apply one input transaction to the shadow state; queue the bytes it produces.
    task automatic pack_symbol_bits(input in_item_t it);
        logic [CODE_W-1:0] value;
        logic [7:0]        run_bytes [GROUP_BYTES];
        int                len;
        int                nrun;
        int                i;
        out_item_t         res;
        nrun = 0;
        if (it.action == ACT_LOAD) begin
            // load: saturate the length, keep only the low code bits
            if (int'(it.symbol) < SYMBOL_COUNT) begin
                len = int'(it.code_length);
                if (len > CODE_CAP) len = CODE_CAP;
                value = it.code_value;
                if (len < 32) value = value & ((32'd1 << len) - 32'd1);
                code_bits[it.symbol] = value;
                code_len[it.symbol]  = len;
            end
        end else begin
            // encode: shift code bits in MSB first, emit each full byte
            if (int'(it.symbol) < SYMBOL_COUNT) begin
                for (i = code_len[it.symbol]; i > 0; i--) begin
                    acc_byte = {acc_byte[6:0], code_bits[it.symbol][i-1]};
                    acc_count++;
                    if (acc_count == 8) begin
                        run_bytes[nrun] = acc_byte;
                        nrun++;
                        acc_byte  = '0;
                        acc_count = 0;
                    end
                end
            end
            // end of stream: flush pending bits left-aligned, or a zero byte
            if (it.end_of_stream) begin
                run_bytes[nrun] = acc_byte << (8 - acc_count);
                nrun++;
                acc_byte  = '0;
                acc_count = 0;
            end
        end
        for (i = 0; i < nrun; i++) begin
            res.out_byte    = run_bytes[i];
            res.last_of_run = (i == nrun - 1);
            expected_bytes.push_back(res);
        end
    endtask

    // Watch both channels at the rising edge
    always @(posedge aclk) begin : watch_blk
        out_item_t want;
        int        k;
        if (!aresetn) begin
            for (k = 0; k < SYMBOL_COUNT; k++) begin
                code_bits[k] = '0;
                code_len[k]  = 0;
            end
            acc_byte  = '0;
            acc_count = 0;
            expected_bytes.delete();
        end else begin
            if (s_valid && s_ready) pack_symbol_bits(s_data);
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected result byte", m_data.out_byte, 0);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_data.out_byte !== want.out_byte)
                        report_mismatch("out_byte", m_data.out_byte, want.out_byte);
                    if (m_data.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", m_data.last_of_run, want.last_of_run);
                end
            end
        end
        bytes_owed = expected_bytes.size();
    end

    initial begin
        fail_count = 0;
        bytes_owed = 0;
    end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for huffman_code_bit_packer_unit: clock, reset, stimulus,
// receiver back-pressure, watchdog and verdict.
// Depends on hcbp_pkg and hcbp_stream_checker.

module tb_top;
    import hcbp_pkg::*;

    localparam int RANDOM_ITEMS = 150;
    localparam int HOLD_CYCLES  = 300;
    // Longest quiet stretch is the receiver hold-off; allow plenty on top.
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    int fail_count;
    int bytes_owed;
    int burst_left;
    int idle_cycles;
    bit hold_req;

    huffman_code_bit_packer_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    hcbp_stream_checker u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .bytes_owed (bytes_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic in_item_t make_item(input logic act, input logic [7:0] sym,
                                           input logic [31:0] value,
                                           input logic [5:0] len, input logic eos);
        in_item_t it;
        it.action        = act;
        it.symbol        = sym;
        it.code_value    = value;
        it.code_length   = len;
        it.end_of_stream = eos;
        return it;
    endfunction

    // Random transaction: mostly encodes of a small symbol set, short codes
    function automatic in_item_t rand_item();
        in_item_t it;
        int       r;
        it.action = ($urandom_range(0, 9) < 3) ? ACT_LOAD : ACT_ENCODE;
        r = $urandom_range(0, 9);
        if (r < 7)       it.symbol = 8'($urandom_range(0, 15));
        else if (r == 7) it.symbol = 8'd255;
        else             it.symbol = 8'($urandom);
        it.code_value = $urandom;
        r = $urandom_range(0, 19);
        if (r < 12)      it.code_length = 6'($urandom_range(1, 12));
        else if (r < 14) it.code_length = 6'd0;
        else if (r < 16) it.code_length = 6'd32;
        else if (r < 18) it.code_length = 6'($urandom_range(13, 31));
        else             it.code_length = 6'($urandom_range(33, 63));
        it.end_of_stream = ($urandom_range(0, 6) == 0);
        return it;
    endfunction

    // Offer one transaction in bursts with random gaps; returns at the
    // falling edge after acceptance.
    task automatic offer(input in_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Receiver: random ready patterns in segments, plus one long hold-off on request
    initial begin : rx_pattern
        int mode;
        int seg;
        int k;
        m_ready <= 1'b0;
        seg = 0;
        k   = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                if (seg == 0) begin
                    mode = $urandom_range(0, 3);
                    seg  = $urandom_range(10, 60);
                end
                seg--;
                k++;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= (k % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int n;
        s_valid    <= 1'b0;
        s_data     <= '0;
        aresetn    <= 1'b0;
        hold_req    = 1'b0;
        burst_left  = 0;
        idle_cycles = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: table loads incl. length saturation, masking, eos on a load
        offer(make_item(ACT_LOAD,   8'd1,   32'h0000_0001, 6'd1,  1'b0));
        offer(make_item(ACT_LOAD,   8'd255, 32'hFFFF_FFFF, 6'd32, 1'b0));
        offer(make_item(ACT_LOAD,   8'd2,   32'hA5A5_A5A5, 6'd63, 1'b0));
        offer(make_item(ACT_LOAD,   8'd3,   32'hFFFF_FFFF, 6'd3,  1'b1));
        offer(make_item(ACT_LOAD,   8'd4,   32'h0000_005A, 6'd8,  1'b0));
        offer(make_item(ACT_LOAD,   8'd0,   32'hDEAD_BEEF, 6'd0,  1'b0));
        // unloaded symbol with end of stream: empty flush
        offer(make_item(ACT_ENCODE, 8'd9,   32'hFFFF_FFFF, 6'd63, 1'b1));
        offer(make_item(ACT_ENCODE, 8'd0,   32'h0,         6'd0,  1'b0));
        offer(make_item(ACT_ENCODE, 8'd1,   32'h0,         6'd0,  1'b0));
        offer(make_item(ACT_ENCODE, 8'd255, 32'h0,         6'd0,  1'b0));
        // four full bytes plus the flush byte
        offer(make_item(ACT_ENCODE, 8'd2,   32'h0,         6'd0,  1'b1));
        offer(make_item(ACT_ENCODE, 8'd3,   32'h0,         6'd0,  1'b0));
        offer(make_item(ACT_ENCODE, 8'd4,   32'h0,         6'd0,  1'b0));
        offer(make_item(ACT_ENCODE, 8'd3,   32'h0,         6'd0,  1'b1));
        // byte fills exactly, then a flush with nothing pending
        offer(make_item(ACT_ENCODE, 8'd4,   32'h0,         6'd0,  1'b1));
        offer(make_item(ACT_LOAD,   8'd128, 32'h8000_0000, 6'd32, 1'b0));
        offer(make_item(ACT_ENCODE, 8'd128, 32'hFFFF_FFFF, 6'd63, 1'b1));
        offer(make_item(ACT_LOAD,   8'd255, 32'h1234_5678, 6'd33, 1'b0));
        offer(make_item(ACT_ENCODE, 8'd1,   32'h0,         6'd0,  1'b0));
        offer(make_item(ACT_ENCODE, 8'd255, 32'h0,         6'd0,  1'b1));
        offer(make_item(ACT_LOAD,   8'd7,   32'h0000_0000, 6'd7,  1'b0));
        offer(make_item(ACT_ENCODE, 8'd7,   32'h0,         6'd0,  1'b0));
        offer(make_item(ACT_ENCODE, 8'd1,   32'h0,         6'd0,  1'b1));

        // Random part with one receiver hold-off and one full drain
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 50) hold_req = 1'b1;
            if (n == 100) begin
                s_valid <= 1'b0;
                while (bytes_owed != 0) @(negedge aclk);
                repeat (4) @(negedge aclk);
                burst_left = 1;
            end
            offer(rand_item());
        end
        s_valid <= 1'b0;

        while (bytes_owed != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/hcbp_pkg.sv
src/hcbp_code_store.sv
src/hcbp_bit_packer.sv
src/hcbp_byte_serializer.sv
src/huffman_code_bit_packer_unit.sv
verif/hcbp_stream_checker.sv
verif/tb_top.sv
